>>> rtl/udpk_pkg.sv
// Shared types, constants and the CRC16 byte update for the USB data packetizer.
package udpk_pkg;

   localparam logic [7:0]  SYNC_BYTE = 8'h80;
   localparam logic [7:0]  PID_DATA0 = 8'hC3;
   localparam logic [7:0]  PID_DATA1 = 8'h4B;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;
   localparam logic [15:0] CRC_POLY  = 16'hA001;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // One classified input item, as queued between front and back.
   typedef struct packed {
      logic [7:0]  data;
      logic        head;       // packet opens here: sync and PID first
      logic        pid_data1;
      logic        tail;       // packet closes here: CRC follows
      logic        last;       // message ends with this packet
      logic [15:0] crc;        // final (complemented) CRC, valid when tail
   } entry_type;

   typedef enum logic [2:0] {
      ST_START,
      ST_PID,
      ST_DATA,
      ST_CRC_LO,
      ST_CRC_HI
   } step_type;

   // Reflected CRC16 update over one byte, LSB first.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> rtl/udpk_front.sv
// Front end: accepts payload bytes, tracks packet position, PID and CRC.
module udpk_front import udpk_pkg::*; #(
   parameter int MAX_PAYLOAD = 8
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   input  logic [7:0] req_payload_byte,
   input  logic      req_message_end,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   localparam int CNT_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             pid_ff, pid_in;
   logic [15:0]      crc_ff, crc_in;
   logic [15:0]      crc_next;
   logic             full;
   logic             tail;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign crc_next  = crc_feed(crc_ff, req_payload_byte);
   assign full      = (count_ff == CNT_W'(MAX_PAYLOAD - 1));
   assign tail      = full || req_message_end;

   always_comb begin
      q_entry.data      = req_payload_byte;
      q_entry.head      = (count_ff == '0);
      q_entry.pid_data1 = pid_ff;
      q_entry.tail      = tail;
      q_entry.last      = req_message_end;
      q_entry.crc       = ~crc_next;

      count_in = count_ff;
      pid_in   = pid_ff;
      crc_in   = crc_ff;
      if (q_push) begin
         if (tail) begin
            count_in = '0;
            crc_in   = CRC_INIT;
            pid_in   = req_message_end ? 1'b1 : !pid_ff;
         end else begin
            count_in = count_ff + 1'b1;
            crc_in   = crc_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pid_ff   <= 1'b1;
         crc_ff   <= CRC_INIT;
      end else begin
         count_ff <= count_in;
         pid_ff   <= pid_in;
         crc_ff   <= crc_in;
      end
   end

endmodule

>>> rtl/udpk_queue.sv
// Small FIFO of classified items between front and back.
module udpk_queue import udpk_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      valid,
   output entry_type head_entry
);

   entry_type         mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign valid      = (count_ff != '0);
   assign head_entry = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (!push && pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/udpk_back.sv
// Back end: sequences sync, PID, payload and CRC bytes into the output register.
module udpk_back import udpk_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  entry_type  q_entry,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_packet_end,
   output logic       rsp_message_done,
   output logic       rsp_run_last
);

   step_type   state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       pend_ff, pend_in;
   logic       mdone_ff, mdone_in;
   logic       rlast_ff, rlast_in;
   logic       advance;
   logic       entry_done;

   assign advance = q_valid && (!out_valid_ff || rsp_ready);
   assign q_pop   = advance && entry_done;

   always_comb begin
      state_in   = state_ff;
      byte_in    = q_entry.data;
      pend_in    = 1'b0;
      mdone_in   = 1'b0;
      entry_done = 1'b0;
      case (state_ff)
         ST_START: begin
            if (q_entry.head) begin
               byte_in  = SYNC_BYTE;
               state_in = ST_PID;
            end else begin
               entry_done = !q_entry.tail;
               state_in   = q_entry.tail ? ST_CRC_LO : ST_START;
            end
         end
         ST_PID: begin
            byte_in  = q_entry.pid_data1 ? PID_DATA1 : PID_DATA0;
            state_in = ST_DATA;
         end
         ST_DATA: begin
            entry_done = !q_entry.tail;
            state_in   = q_entry.tail ? ST_CRC_LO : ST_START;
         end
         ST_CRC_LO: begin
            byte_in  = q_entry.crc[7:0];
            state_in = ST_CRC_HI;
         end
         ST_CRC_HI: begin
            byte_in    = q_entry.crc[15:8];
            pend_in    = 1'b1;
            mdone_in   = q_entry.last;
            entry_done = 1'b1;
            state_in   = ST_START;
         end
         default: begin
            state_in = ST_START;
         end
      endcase
      rlast_in = entry_done;
      if (!advance) state_in = state_ff;

      out_valid_in = out_valid_ff;
      if (advance) out_valid_in = 1'b1;
      else if (rsp_ready) out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_START;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff  <= byte_in;
         pend_ff  <= pend_in;
         mdone_ff <= mdone_in;
         rlast_ff <= rlast_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_packet_end   = pend_ff;
   assign rsp_message_done = mdone_ff;
   assign rsp_run_last     = rlast_ff;

   // Mid-entry the item being sequenced must still sit at the queue head.
   a_entry_held: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_START |-> q_valid)
      else $error("sequencer mid-item with empty queue");

   a_mdone_on_pend: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && mdone_ff |-> pend_ff)
      else $error("message_done without packet_end");

   a_pend_is_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && pend_ff |-> rlast_ff)
      else $error("packet_end not on last result of its item");

   a_crc_hi_follows_lo: assert property (@(posedge clock) disable iff (reset)
      advance && state_ff == ST_CRC_LO |=> state_ff == ST_CRC_HI)
      else $error("CRC high byte did not follow low byte");

endmodule

>>> rtl/usb_data_packetizer_crc16.sv
// Top level of the USB data packetizer with CRC16.
//
// Takes a message as a stream of payload items (one byte plus an end
// marker) and emits USB data packets byte by byte: sync 0x80, PID
// (DATA1, DATA0, ... restarting at DATA1 for every message), up to
// MAX_PAYLOAD payload bytes, then the complemented reflected CRC16
// (poly 0xA001, init 0xFFFF), low byte first. A packet closes when full
// or on the message end, so no zero-length packet appears. The front end
// classifies each item and updates the CRC in the accept cycle; a
// four-item queue decouples it from the back end, which sends one output
// byte per cycle while the receiver is ready and the queue holds an item,
// through a registered output stage. Each item yields 1 to 5 output bytes
// (about 1.5 on average at MAX_PAYLOAD = 8), so the sustained rate is set
// by the output sequencer. An accepted item passes through the queue and
// then the output register. rsp_run_last marks the last byte caused by an
// item; rsp_packet_end and rsp_message_done sit on the CRC high byte.
module usb_data_packetizer_crc16 import udpk_pkg::*; #(
   parameter int MAX_PAYLOAD = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_payload_byte,
   input  logic       req_message_end,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_packet_end,
   output logic       rsp_message_done,
   output logic       rsp_run_last
);

   entry_type push_entry;
   entry_type head_entry;
   logic      q_push;
   logic      q_full;
   logic      q_pop;
   logic      q_valid;

   // Front: accept, classify, CRC.
   udpk_front #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload_byte (req_payload_byte),
      .req_message_end  (req_message_end),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_entry          (push_entry)
   );

   udpk_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .valid      (q_valid),
      .head_entry (head_entry)
   );

   // Back: byte sequencer and output register.
   udpk_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_entry          (head_entry),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_packet_end   (rsp_packet_end),
      .rsp_message_done (rsp_message_done),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

>>> tb/sv/usb_data_packetizer_crc16_checker.sv
// Checker for the USB data packetizer: predicts every output byte and compares it.
`timescale 1ns / 1ps
module usb_data_packetizer_crc16_checker import udpk_pkg::*; #(
   parameter int MAX_PAYLOAD = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  logic [7:0] req_payload_byte,
   input  logic       req_message_end,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_packet_end,
   input  logic       rsp_message_done,
   input  logic       rsp_run_last,
   output int         fail_count,
   output int         due_count
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_end;
      logic       message_done;
      logic       run_last;
   } pkt_byte_type;

   pkt_byte_type due_bytes[$];
   logic         next_is_data1 = 1'b1;
   int           fill = 0;
   logic [15:0]  crc_acc = CRC_INIT;

   initial begin
      fail_count = 0;
      due_count  = 0;
   end

   // reflected CRC16, one data bit at a time, LSB first
   function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = crc;
      for (int i = 0; i < 8; i++) begin
         fb = r[0] ^ b[i];
         r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
      end
      return r;
   endfunction

   task automatic push_byte(logic [7:0] b, logic pend, logic mdone, logic lastb);
      due_bytes.push_back({b, pend, mdone, lastb});
   endtask

   task automatic predict_packet_bytes(logic [7:0] data, logic msg_end);
      logic [15:0] fin;
      logic        closes;
      closes = msg_end || (fill + 1 >= MAX_PAYLOAD);
      if (fill == 0) begin
         push_byte(SYNC_BYTE, 1'b0, 1'b0, 1'b0);
         push_byte(next_is_data1 ? PID_DATA1 : PID_DATA0, 1'b0, 1'b0, 1'b0);
      end
      push_byte(data, 1'b0, 1'b0, !closes);
      crc_acc = crc16_step(crc_acc, data);
      fill++;
      if (closes) begin
         fin = ~crc_acc;
         push_byte(fin[7:0], 1'b0, 1'b0, 1'b0);
         push_byte(fin[15:8], 1'b1, msg_end, 1'b1);
         crc_acc       = CRC_INIT;
         fill          = 0;
         next_is_data1 = msg_end ? 1'b1 : !next_is_data1;
      end
   endtask

   task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pkt_byte_type want;
      if (reset) begin
         due_bytes.delete();
         next_is_data1 = 1'b1;
         fill          = 0;
         crc_acc       = CRC_INIT;
      end else begin
         if (req_valid && req_ready)
            predict_packet_bytes(req_payload_byte, req_message_end);
         if (rsp_valid && rsp_ready) begin
            if (due_bytes.size() == 0) begin
               $error("unexpected item: out_byte %0h", rsp_out_byte);
               fail_count++;
            end else begin
               want = due_bytes.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("packet_end", {7'd0, want.packet_end}, {7'd0, rsp_packet_end});
               check_field("message_done", {7'd0, want.message_done},
                           {7'd0, rsp_message_done});
               check_field("run_last", {7'd0, want.run_last}, {7'd0, rsp_run_last});
            end
         end
      end
      due_count = due_bytes.size();
   end

endmodule

>>> tb/sv/usb_data_packetizer_crc16_tb.sv
// Testbench top for the USB data packetizer: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module usb_data_packetizer_crc16_tb;

   localparam int PKT_MAX     = 8;
   // worst case is far below this: ~330 items, 5 bytes each, random stalls
   localparam int CYCLE_LIMIT = 200000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_payload_byte = 8'h00;
   logic       req_message_end = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_packet_end;
   logic       rsp_message_done;
   logic       rsp_run_last;

   int fail_count;
   int due_count;
   int send_idle_pct = 36;
   int recv_idle_pct = 51;
   int hold_cycles = 0;
   int items_sent = 0;
   int cycle_count = 0;

   usb_data_packetizer_crc16 #(.MAX_PAYLOAD(PKT_MAX)) i_dut (.*);

   usb_data_packetizer_crc16_checker #(.MAX_PAYLOAD(PKT_MAX)) i_checker (.*);

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run guard: a hang anywhere ends the run as a failure
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("usb_data_packetizer_crc16: mismatch");
         $finish;
      end
   end

   // Receiver: random back-pressure, or a forced hold-off while hold_cycles
   // counts down. hold_cycles is only loaded at a rising edge, so there is
   // no race with this falling-edge process.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready = 1'b0;
         hold_cycles--;
      end else begin
         rsp_ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one item. Called at a falling edge; returns at the falling edge
   // after acceptance with valid still high, so back-to-back items keep
   // valid asserted. Valid only drops on a random gap or an explicit pause.
   task automatic send_item(logic [7:0] b, logic msg_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_payload_byte = b;
      req_message_end  = msg_end;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // one whole message, random content, end marker on the final byte
   task automatic send_message(int len);
      for (int i = 0; i < len; i++)
         send_item(8'($urandom_range(255)), i == len - 1);
   endtask

   // Random messages, mostly short; some land exactly on packet multiples
   // (end marker on a full packet) and some span several packets so the
   // PID toggles DATA1 -> DATA0 -> DATA1 within one message.
   task automatic run_random(int count);
      int stop_at;
      int pick;
      int len;
      stop_at = items_sent + count;
      while (items_sent < stop_at) begin
         pick = $urandom_range(9);
         if (pick < 6)
            len = $urandom_range(1, 10);
         else if (pick < 8)
            len = PKT_MAX * $urandom_range(1, 3);
         else
            len = $urandom_range(11, 26);
         send_message(len);
      end
   endtask

   // sender goes quiet until every predicted byte has come out
   task automatic wait_drained();
      req_valid = 1'b0;
      while (due_count != 0) @(negedge clock);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // --- directed ---
      // single-byte message: sync, PID, data, CRC all from one item
      send_item(8'h00, 1'b1);
      // message ends exactly on a full packet
      for (int i = 0; i < PKT_MAX; i++)
         send_item(8'hFF, i == PKT_MAX - 1);
      // one past full: second packet must carry DATA0
      for (int i = 0; i <= PKT_MAX; i++)
         send_item(8'(i * 29), i == PKT_MAX);
      // next message restarts at DATA1; field extremes
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hA5, 1'b1);

      // --- random, sender 36% / receiver 51% idle ---
      run_random(100);
      wait_drained();

      // --- long receiver hold-off: queue fills and input stalls ---
      @(posedge clock);
      hold_cycles = 80;
      @(negedge clock);
      send_idle_pct = 0;
      send_message(30);
      wait_drained();

      // --- random, roles swapped ---
      send_idle_pct = 51;
      recv_idle_pct = 36;
      run_random(100);

      // --- random, full rate both sides ---
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(70);

      wait_drained();
      // keep clocking to catch any stray output bytes
      repeat (12) @(negedge clock);

      if (fail_count == 0)
         $display("usb_data_packetizer_crc16: match");
      else
         $display("usb_data_packetizer_crc16: mismatch");
      $finish;
   end

endmodule
